// ===== hw/rtl/pstf_pkg.sv =====
package pstf_pkg;

    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 4;
    localparam int STATUS_W = 2;
    localparam int READ_W   = 4;
    localparam int FP_W     = 32;
    localparam int ECNT_W   = 11;
    localparam int FCNT_W   = 13;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 13;

    localparam logic [CMD_W-1:0] CMD_RD_STATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_STATE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RD_FLAG    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_FLAG    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINGERPRINT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_FLAG_COUNT  = 1'd1;

    localparam logic [ECNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;
    localparam logic [FCNT_W-1:0] FLAG_COUNT_RST  = 13'd4096;

    localparam logic [FP_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [FP_W-1:0] FNV_PRIME = 32'd16777619;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [READ_W-1:0]   read_value;
        logic [FP_W-1:0]     fingerprint;
    } t_out;

    typedef struct packed {
        logic start;
        logic step;
    } t_fnv_ctl;

endpackage

// ===== hw/rtl/pstf_ram.sv =====
module pstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pstf_fnv.sv =====
module pstf_fnv (
    input  logic              i_clk,
    input  pstf_pkg::t_fnv_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [31:0]       o_hash
);

    import pstf_pkg::*;

    logic [FP_W-1:0] r_h;
    logic [FP_W-1:0] n_h;
    logic [FP_W-1:0] mix;
    logic [FP_W-1:0] prod;

    // one fnv-1a round: xor the byte in, keep the low word of the product
    always_comb begin
        mix  = r_h ^ {24'd0, i_byte};
        prod = mix * FNV_PRIME;
        n_h  = r_h;
        if (i_ctl.start) begin
            n_h = FNV_BASIS;
        end else if (i_ctl.step) begin
            n_h = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
    end

    assign o_hash = r_h;

endmodule

// ===== hw/rtl/packed_state_table_fingerprint_unit.sv =====
// channel | dir | handshake                 | payload
// in      | in  | i_in_valid / o_in_ready   | i_in  (command, index, value)
// out     | out | o_out_valid / i_out_ready | o_out (status, read_value, fingerprint)
// cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// state and flag reads and writes do one byte-ram read, then modify and write back
// index or value errors and unknown commands answer without touching the ram
// fingerprint hashes the used bytes from address 0 up, one byte per cycle
// clear zeroes all STORE_DEPTH ram bytes; after reset a sweep over every byte zeroes the ram
// one item at a time; a finished result waits in the output register and a full one stalls

module packed_state_table_fingerprint_unit #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_FLAGS   = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pstf_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pstf_pkg::t_out               o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pstf_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [pstf_pkg::CFG_DW-1:0]  i_cfg_data
);

    import pstf_pkg::*;

    localparam int STATE_BYTES_MAX = (MAX_ENTRIES + 1) / 2;
    localparam int FLAG_BYTES_MAX  = (MAX_FLAGS + 7) / 8;
    localparam int STORE_DEPTH     = STATE_BYTES_MAX + FLAG_BYTES_MAX;
    localparam int AW              = $clog2(STORE_DEPTH);
    localparam int SW              = AW + 1;
    localparam logic [SW-1:0] LAST_ADDR = SW'(STORE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_HASH,
        S_CLR,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [2:0]          r_sub, n_sub;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_n, n_n;
    logic                r_pend, n_pend;
    t_out                r_res, n_res;
    t_out                r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [ECNT_W-1:0]   r_entry_count;
    logic [FCNT_W-1:0]   r_flag_count;

    logic                in_fire;
    logic                out_free;
    logic [ECNT_W-1:0]   used_e;
    logic [FCNT_W-1:0]   used_f;
    logic [ECNT_W:0]     state_bytes;
    logic [FCNT_W-3:0]   flag_bytes;
    logic [FCNT_W:0]     flag_sum;
    logic [31:0]         used_bytes;
    logic [31:0]         pos_e;
    logic [31:0]         pos_f;
    logic                bad_e;
    logic                bad_f;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;
    logic [7:0]          new_byte;
    logic [READ_W-1:0]   rd_val;
    t_fnv_ctl            fnv_ctl;
    logic [FP_W-1:0]     hash;

    pstf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pstf_fnv u_fnv (
        .i_clk  (i_clk),
        .i_ctl  (fnv_ctl),
        .i_byte (ram_rdata),
        .o_hash (hash)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // region geometry from the clamped counts
    always_comb begin
        used_e = (32'(r_entry_count) > 32'(MAX_ENTRIES)) ? ECNT_W'(MAX_ENTRIES)
                                                         : r_entry_count;
        used_f = (32'(r_flag_count) > 32'(MAX_FLAGS)) ? FCNT_W'(MAX_FLAGS)
                                                      : r_flag_count;
        state_bytes = ({1'b0, used_e} + (ECNT_W+1)'(1)) >> 1;
        flag_sum    = {1'b0, used_f} + (FCNT_W+1)'(7);
        flag_bytes  = flag_sum[FCNT_W:3];
        used_bytes  = 32'(state_bytes) + 32'(flag_bytes);
        pos_e       = 32'(i_in.index[INDEX_W-1:1]);
        pos_f       = 32'(state_bytes) + 32'(i_in.index[INDEX_W-1:3]);
        bad_e       = {1'b0, i_in.index} >= {2'b0, used_e};
        bad_f       = {1'b0, i_in.index} >= used_f;
    end

    // byte update and read-out for the item held in S_MOD
    always_comb begin
        new_byte = ram_rdata;
        rd_val   = '0;
        case (r_cmd)
            CMD_RD_STATE: begin
                rd_val = r_sub[0] ? ram_rdata[7:4] : ram_rdata[3:0];
            end
            CMD_WR_STATE: begin
                new_byte = r_sub[0] ? {r_val, ram_rdata[3:0]} : {ram_rdata[7:4], r_val};
            end
            CMD_RD_FLAG: begin
                rd_val = {3'd0, ram_rdata[r_sub]};
            end
            CMD_WR_FLAG: begin
                new_byte[r_sub] = r_val[0];
            end
            default: begin
                new_byte = ram_rdata;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_sub       = r_sub;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_pend      = r_pend;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[AW-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_cnt[AW-1:0];
        fnv_ctl     = '0;

        case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + SW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd   = i_in.command;
                    n_sub   = i_in.index[2:0];
                    n_val   = i_in.value;
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_in.command)
                        CMD_RD_STATE, CMD_WR_STATE: begin
                            if (bad_e) begin
                                n_res.status = ST_BAD_INDEX;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_e[AW-1:0];
                                n_cnt     = pos_e[SW-1:0];
                                n_state   = S_MOD;
                            end
                        end
                        CMD_RD_FLAG, CMD_WR_FLAG: begin
                            if (bad_f) begin
                                n_res.status = ST_BAD_INDEX;
                            end else if (i_in.command == CMD_WR_FLAG &&
                                         i_in.value > VALUE_W'(1)) begin
                                n_res.status = ST_BAD_VALUE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_f[AW-1:0];
                                n_cnt     = pos_f[SW-1:0];
                                n_state   = S_MOD;
                            end
                        end
                        CMD_FINGERPRINT: begin
                            fnv_ctl.start = 1'b1;
                            n_cnt   = '0;
                            n_n     = used_bytes[SW-1:0];
                            n_pend  = 1'b0;
                            n_state = S_HASH;
                        end
                        CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                // ram read data holds while the output register is full
                if (out_free) begin
                    ram_we    = (r_cmd == CMD_WR_STATE) || (r_cmd == CMD_WR_FLAG);
                    // byte address was parked in r_cnt at the transfer
                    ram_waddr = r_cnt[AW-1:0];
                    ram_wdata = new_byte;
                    n_out             = '0;
                    n_out.status      = ST_OK;
                    n_out.read_value  = rd_val;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_HASH: begin
                fnv_ctl.step = r_pend;
                if (r_cnt < r_n) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + SW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_res             = '0;
                        n_res.fingerprint = hash;
                        n_state           = S_DONE;
                    end
                end
            end
            S_CLR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + SW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cnt         <= '0;
            r_n           <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_entry_count <= ENTRY_COUNT_RST;
            r_flag_count  <= FLAG_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[ECNT_W-1:0];
                    CFG_FLAG_COUNT:  r_flag_count  <= i_cfg_data[FCNT_W-1:0];
                    default: begin
                        r_entry_count <= r_entry_count;
                    end
                endcase
            end
        end
        r_cmd <= n_cmd;
        r_sub <= n_sub;
        r_val <= n_val;
        r_res <= n_res;
        r_out <= n_out;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("ram written while idle");

    a_hash_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH) |-> (r_cnt <= r_n))
        else $error("fingerprint walk past used bytes");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule
